// ===== hdl/sbb_pkg.sv =====
// Shared types, constants and helpers of the spectrum bar ballistics block.
package sbb_pkg;

    localparam int NUM_BARS    = 512;
    localparam int BAR_W       = 9;
    localparam int BAR_AW      = (NUM_BARS > 1) ? $clog2(NUM_BARS) : 1;
    localparam int LEVEL_W     = 17;
    localparam int CEIL_W      = 16;
    localparam int EL_W        = 10;
    localparam int WEIGHT_W    = 9;
    localparam int HOLD_W      = 14;
    localparam int RATE_W      = 15;
    localparam int AGE_W       = 16;
    localparam int FALL_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;
    localparam int QUEUE_DEPTH = 4;

    localparam int WEIGHT_ONE  = 256;
    localparam int WEIGHT_FRAC = 8;
    localparam int ROUND_HALF  = 128;
    localparam int RESET_FLOOR = -20480;

    // Fall step: round(rate * elapsed / 1000) as floor((p + 500) / 8) / 125,
    // where the division by 125 is a multiplication by a rounded-up reciprocal.
    localparam int FR_PROD_W     = RATE_W + EL_W;
    localparam int ROUND_ADD     = 500;
    localparam int DIV_PRE_SHIFT = 3;
    localparam int DIV_N_W       = FR_PROD_W - DIV_PRE_SHIFT;
    localparam int RECIP_W       = 23;
    localparam int RECIP_SHIFT   = 29;
    localparam int MUL_W         = DIV_N_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 23'd4294968;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    typedef logic signed [LEVEL_W-1:0] level_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK  = 3'd0,
        CFG_RELEASE = 3'd1,
        CFG_HOLD_ON = 3'd2,
        CFG_HOLD_MS = 3'd3,
        CFG_RATE    = 3'd4,
        CFG_FLOOR   = 3'd5,
        CFG_CEILING = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0]      attack_weight;
        logic [WEIGHT_W-1:0]      release_weight;
        logic                     peak_hold_on;
        logic [HOLD_W-1:0]        hold_time_ms;
        logic [RATE_W-1:0]        fall_rate;
        logic signed [LEVEL_W-1:0] floor_level;
        logic signed [CEIL_W-1:0]  ceiling_level;
    } cfg_t;

    typedef struct packed {
        logic [BAR_W-1:0]  bar;
        logic              in_range;
        level_t            target;
        logic [EL_W-1:0]   elapsed;
        logic [FALL_W-1:0] fall;
    } q_item_t;

    typedef struct packed {
        level_t           level;
        level_t           peak;
        logic [AGE_W-1:0] age;
    } bar_state_t;

    localparam int STATE_W = $bits(bar_state_t);

    function automatic logic [BAR_AW-1:0] bar_addr(input logic [BAR_W-1:0] bar);
        return BAR_AW'(bar);
    endfunction

endpackage

// ===== hdl/sbb_if.sv =====
// Channel interfaces of the spectrum bar ballistics block.
interface sbb_in_if;
    import sbb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [BAR_W-1:0]          bar_index;
    logic signed [LEVEL_W-1:0] target_level;
    logic [EL_W-1:0]           elapsed_ms;

    modport source (output valid, bar_index, target_level, elapsed_ms, input ready);
    modport sink (input valid, bar_index, target_level, elapsed_ms, output ready);
endinterface

interface sbb_out_if;
    import sbb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [BAR_W-1:0]          bar_out;
    logic signed [LEVEL_W-1:0] level_out;
    logic signed [LEVEL_W-1:0] peak_out;

    modport source (output valid, bar_out, level_out, peak_out, input ready);
    modport sink (input valid, bar_out, level_out, peak_out, output ready);
endinterface

interface sbb_cfg_if;
    import sbb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/spectrum_bar_ballistics_peak_hold.sv =====
// Top level of the spectrum bar ballistics block with peak hold and its register file.
//
//  Port   Direction  Beat carries
//  cfg    sink       register index and write data
//  bars   sink       bar index, target level, elapsed milliseconds
//  meter  source     bar index, smoothed level, peak level
//
// One beat is accepted per clock cycle when nothing stalls; a result passes through
// two front stages, the queue and three back stages.
// The back part reads and writes each bar's state in one RAM, with results
// forwarded so that the same bar may come in consecutive beats.
// After reset the RAM is cleared one bar per cycle, all 512 bars, while bars is not ready.
// A stalled meter stops the back part; the queue lets the front keep taking beats until it is full.
module spectrum_bar_ballistics_peak_hold (
    input  logic      clk,
    input  logic      rst_n,
    sbb_cfg_if.sink   cfg,
    sbb_in_if.sink    bars,
    sbb_out_if.source meter
);
    import sbb_pkg::*;

    cfg_t    regs_reg, regs_next;
    logic    clearing;
    logic    push_valid, push_ready, pop_valid, pop_ready;
    q_item_t push_data, pop_data;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_ATTACK:  regs_next.attack_weight  = cfg.data[WEIGHT_W-1:0];
                CFG_RELEASE: regs_next.release_weight = cfg.data[WEIGHT_W-1:0];
                CFG_HOLD_ON: regs_next.peak_hold_on   = cfg.data[0];
                CFG_HOLD_MS: regs_next.hold_time_ms   = cfg.data[HOLD_W-1:0];
                CFG_RATE:    regs_next.fall_rate      = cfg.data[RATE_W-1:0];
                CFG_FLOOR:   regs_next.floor_level    = signed'(cfg.data[LEVEL_W-1:0]);
                CFG_CEILING: regs_next.ceiling_level  = signed'(cfg.data[CEIL_W-1:0]);
                default:     regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.attack_weight  <= WEIGHT_W'(256);
            regs_reg.release_weight <= WEIGHT_W'(64);
            regs_reg.peak_hold_on   <= 1'b1;
            regs_reg.hold_time_ms   <= HOLD_W'(500);
            regs_reg.fall_rate      <= RATE_W'(5120);
            regs_reg.floor_level    <= LEVEL_W'(RESET_FLOOR);
            regs_reg.ceiling_level  <= '0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    sbb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .regs       (regs_reg),
        .enable     (!clearing),
        .bars       (bars),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    sbb_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    sbb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .regs      (regs_reg),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .clearing  (clearing),
        .meter     (meter)
    );
endmodule

// ===== hdl/sbb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== hdl/sbb_fifo.sv =====
// Short queue of classified beats between the front and back parts.
module sbb_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  sbb_pkg::q_item_t push_data,
    output logic             push_ready,
    output logic             pop_valid,
    output sbb_pkg::q_item_t pop_data,
    input  logic             pop_ready
);
    import sbb_pkg::*;

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    q_item_t           entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

// ===== hdl/sbb_front.sv =====
// Front part: accepts beats, clamps the target and works out the peak fall step.
module sbb_front (
    input  logic             clk,
    input  logic             rst_n,
    input  sbb_pkg::cfg_t    regs,
    input  logic             enable,
    sbb_in_if.sink           bars,
    output logic             push_valid,
    output sbb_pkg::q_item_t push_data,
    input  logic             push_ready
);
    import sbb_pkg::*;

    logic                 f1_valid_reg, f1_valid_next;
    q_item_t              f1_item_reg, f1_item_next;
    logic [FR_PROD_W-1:0] f1_prod_reg, f1_prod_next;
    logic                 f2_valid_reg, f2_valid_next;
    q_item_t              f2_item_reg;
    logic [MUL_W-1:0]     f2_prod_reg, f2_prod_next;
    logic                 f1_take, f2_take, in_fire;
    level_t               ceiling_ext, target_clamped;
    logic [FR_PROD_W:0]   f1_round;
    logic [DIV_N_W-1:0]   f1_div_n;

    assign f2_take     = !f2_valid_reg || push_ready;
    assign f1_take     = !f1_valid_reg || f2_take;
    assign bars.ready  = enable && f1_take;
    assign in_fire     = bars.valid && bars.ready;
    assign ceiling_ext = LEVEL_W'(regs.ceiling_level);

    // When the floor lies above the ceiling, the ceiling wins.
    always_comb
    begin
        target_clamped = bars.target_level;
        if (target_clamped < regs.floor_level)
        begin
            target_clamped = regs.floor_level;
        end
        if (target_clamped > ceiling_ext)
        begin
            target_clamped = ceiling_ext;
        end
    end

    always_comb
    begin
        f1_valid_next = f1_take ? in_fire : f1_valid_reg;
        f2_valid_next = f2_take ? f1_valid_reg : f2_valid_reg;

        f1_item_next.bar      = bars.bar_index;
        f1_item_next.in_range = (32'(bars.bar_index) < 32'(NUM_BARS));
        f1_item_next.target   = target_clamped;
        f1_item_next.elapsed  = bars.elapsed_ms;
        f1_item_next.fall     = '0;
        f1_prod_next = FR_PROD_W'(regs.fall_rate) * FR_PROD_W'(bars.elapsed_ms);
    end

    assign f1_round     = (FR_PROD_W+1)'(f1_prod_reg) + (FR_PROD_W+1)'(ROUND_ADD);
    assign f1_div_n     = f1_round[FR_PROD_W-1:DIV_PRE_SHIFT];
    assign f2_prod_next = MUL_W'(f1_div_n) * MUL_W'(RECIP_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= f1_valid_next;
            f2_valid_reg <= f2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            f1_item_reg <= f1_item_next;
            f1_prod_reg <= f1_prod_next;
        end
        if (f2_take && f1_valid_reg)
        begin
            f2_item_reg <= f1_item_reg;
            f2_prod_reg <= f2_prod_next;
        end
    end

    always_comb
    begin
        push_data      = f2_item_reg;
        push_data.fall = f2_prod_reg[RECIP_SHIFT +: FALL_W];
    end

    assign push_valid = f2_valid_reg;
endmodule

// ===== hdl/sbb_back.sv =====
// Back part: read-modify-write of the bar state, smoothing and peak hold.
module sbb_back (
    input  logic             clk,
    input  logic             rst_n,
    input  sbb_pkg::cfg_t    regs,
    input  logic             pop_valid,
    input  sbb_pkg::q_item_t pop_data,
    output logic             pop_ready,
    output logic             clearing,
    sbb_out_if.source        meter
);
    import sbb_pkg::*;

    localparam int DIFF_W = LEVEL_W + 1;
    localparam int PROD_W = DIFF_W + WEIGHT_W + 1;
    localparam int STEP_W = PROD_W - WEIGHT_FRAC;

    localparam bar_state_t STATE_RESET = '{
        level: LEVEL_W'(RESET_FLOOR),
        peak:  LEVEL_W'(RESET_FLOOR),
        age:   '0
    };

    logic              clear_reg, clear_next;
    logic [BAR_AW-1:0] clr_cnt_reg, clr_cnt_next;

    logic              s1_valid_reg;
    q_item_t           s1_item_reg;
    logic              s2_valid_reg;
    q_item_t           s2_item_reg;
    level_t            s2_level_reg, s2_level_next;
    level_t            s2_peak_reg;
    logic [AGE_W-1:0]  s2_age_reg;
    logic              s3_valid_reg;
    logic [BAR_W-1:0]  s3_bar_reg;
    logic              s3_in_range_reg;
    bar_state_t        s3_state_reg;

    logic              adv;
    logic [STATE_W-1:0] rd_data;
    logic              ram_we;
    logic [BAR_AW-1:0] ram_waddr;
    bar_state_t        ram_wdata;
    bar_state_t        s1_cur, s2_new;

    level_t                   lvl, tgt, pk;
    logic [WEIGHT_W-1:0]      w_raw, w_sat;
    logic signed [WEIGHT_W:0] w_s;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod, prod_r;
    logic signed [STEP_W-1:0] step, lvl_sum;
    logic [AGE_W-1:0]         age;
    logic [AGE_W:0]           age_sum;
    logic signed [DIFF_W-1:0] pk_fall, floor_ext;
    logic                     s3_hits_s1, s2_hits_s1, s3_hits_s2;

    assign adv       = !s3_valid_reg || meter.ready;
    assign pop_ready = adv && !clear_reg;
    assign clearing  = clear_reg;

    // After reset every bar is written with its reset state, one per cycle.
    always_comb
    begin
        clear_next   = clear_reg;
        clr_cnt_next = clr_cnt_reg;
        if (clear_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == BAR_AW'(NUM_BARS - 1))
            begin
                clear_next = 1'b0;
            end
        end
    end

    sbb_ram #(
        .WIDTH (STATE_W),
        .DEPTH (NUM_BARS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (adv),
        .raddr (bar_addr(pop_data.bar)),
        .rdata (rd_data)
    );

    // The RAM returns old data when read and written together, so the write
    // of the previous cycle sits in the output stage and is forwarded from there.
    assign s3_hits_s1 = s3_valid_reg && s3_in_range_reg && (s3_bar_reg == s1_item_reg.bar);
    assign s2_hits_s1 = s2_valid_reg && s2_item_reg.in_range
                        && (s2_item_reg.bar == s1_item_reg.bar);
    assign s3_hits_s2 = s3_valid_reg && s3_in_range_reg && (s3_bar_reg == s2_item_reg.bar);

    always_comb
    begin
        s1_cur = bar_state_t'(rd_data);
        if (s3_hits_s1)
        begin
            s1_cur = s3_state_reg;
        end
        if (s2_hits_s1)
        begin
            s1_cur.level = s2_level_reg;
        end

        lvl   = s1_cur.level;
        tgt   = s1_item_reg.target;
        w_raw = (tgt > lvl) ? regs.attack_weight : regs.release_weight;
        w_sat = (32'(w_raw) > 32'(WEIGHT_ONE)) ? WEIGHT_W'(WEIGHT_ONE) : w_raw;
        w_s   = signed'({1'b0, w_sat});
        diff  = DIFF_W'(tgt) - DIFF_W'(lvl);
        prod  = PROD_W'(diff) * PROD_W'(w_s);
        prod_r  = prod + PROD_W'(ROUND_HALF);
        step    = prod_r[PROD_W-1:WEIGHT_FRAC];
        lvl_sum = STEP_W'(lvl) + step;
        s2_level_next = lvl_sum[LEVEL_W-1:0];
    end

    always_comb
    begin
        pk  = s2_peak_reg;
        age = s2_age_reg;
        if (s3_hits_s2)
        begin
            pk  = s3_state_reg.peak;
            age = s3_state_reg.age;
        end
        floor_ext    = DIFF_W'(regs.floor_level);
        age_sum      = (AGE_W+1)'(age) + (AGE_W+1)'(s2_item_reg.elapsed);
        pk_fall      = DIFF_W'(pk) - signed'(DIFF_W'(s2_item_reg.fall));
        s2_new.level = s2_level_reg;
        if (!regs.peak_hold_on || (s2_level_reg >= pk))
        begin
            s2_new.peak = s2_level_reg;
            s2_new.age  = '0;
        end
        else
        begin
            s2_new.age  = age_sum[AGE_W] ? AGE_MAX : age_sum[AGE_W-1:0];
            s2_new.peak = pk;
            if (s2_new.age > AGE_W'(regs.hold_time_ms))
            begin
                if (pk_fall < floor_ext)
                begin
                    s2_new.peak = regs.floor_level;
                end
                else
                begin
                    s2_new.peak = pk_fall[LEVEL_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        if (clear_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = STATE_RESET;
        end
        else
        begin
            ram_we    = adv && s2_valid_reg && s2_item_reg.in_range;
            ram_waddr = bar_addr(s2_item_reg.bar);
            ram_wdata = s2_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg    <= 1'b1;
            clr_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            clear_reg   <= clear_next;
            clr_cnt_reg <= clr_cnt_next;
            if (adv)
            begin
                s1_valid_reg <= pop_valid && pop_ready;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg     <= pop_data;
            s2_item_reg     <= s1_item_reg;
            s2_level_reg    <= s2_level_next;
            s2_peak_reg     <= s1_cur.peak;
            s2_age_reg      <= s1_cur.age;
            s3_bar_reg      <= s2_item_reg.bar;
            s3_in_range_reg <= s2_item_reg.in_range;
            s3_state_reg    <= s2_new;
        end
    end

    assign meter.valid     = s3_valid_reg;
    assign meter.bar_out   = s3_bar_reg;
    assign meter.level_out = s3_in_range_reg ? s3_state_reg.level : '0;
    assign meter.peak_out  = s3_in_range_reg ? s3_state_reg.peak : '0;
endmodule
